@@ src/rrts_pkg.sv @@
`timescale 1ns / 1ps

package rrts_pkg;

   // Default sizes, handed to the top level as parameter defaults.
   localparam int MAX_THREADS_DEF = 16;
   localparam int ID_BITS_DEF     = 8;

   // Fixed field widths of the channels.
   localparam int OPCODE_W    = 3;
   localparam int TID_W       = 8;
   localparam int ERR_W       = 2;
   localparam int SLICE_W     = 16;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;

   localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(1);

   // Event codes.
   localparam logic [OPCODE_W-1:0] OP_NEW   = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_EXIT  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_BLOCK = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_WAKE  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd4;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_OK          = 2'd0;
   localparam logic [ERR_W-1:0] ERR_NO_ROOM     = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NOT_BLOCKED = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_LOAD
   } state_type;

   typedef struct packed {
      logic accept;
      logic exec;
      logic rd_en;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctrl_status_type;

endpackage

@@ src/round_robin_thread_scheduler_top.sv @@
`timescale 1ns / 1ps
// The result of an item is registered after the controller steps accept, update, run ring
// read and result load. A new item is accepted only once the result of the last one is loaded;
// a stalled result channel holds the controller in the load step.
// Reset is synchronous and active high; it empties the run queue and the blocked set,
// clears the slice counter and sets the slice length register to one tick.

module round_robin_thread_scheduler_top #(
   parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF,
   parameter int ID_BITS     = rrts_pkg::ID_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Event items. tdata from bit 0: opcode[2:0], tid[10:3], zero fill.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rrts_pkg::REQ_DATA_W-1:0] req_tdata,
   // Result items. tdata from bit 0: current_valid[0], current_id[8:1],
   // error_code[10:9], zero fill.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rrts_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Slice length register, written whenever csr_wr_en is high.
   input  logic                            csr_wr_en,
   input  logic [rrts_pkg::SLICE_W-1:0]    csr_wr_data
);

   // The controller walks each item through its phases; the datapath holds the run ring,
   // the blocked set with its parallel compare, the slice counter and the result register.
   rrts_pkg::ctrl_cmd_type    cmd;
   rrts_pkg::ctrl_status_type status;

   rrts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rrts_datapath #(
      .MAX_THREADS (MAX_THREADS),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

@@ src/rrts_ram.sv @@
`timescale 1ns / 1ps

module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/rrts_ctrl.sv @@
`timescale 1ns / 1ps

module rrts_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  rrts_pkg::ctrl_status_type status,
   output rrts_pkg::ctrl_cmd_type    cmd
);

   rrts_pkg::state_type state_ff;
   rrts_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrts_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         rrts_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = rrts_pkg::S_EXEC;
            end
         end
         rrts_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = rrts_pkg::S_READ;
         end
         rrts_pkg::S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = rrts_pkg::S_LOAD;
         end
         rrts_pkg::S_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = rrts_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rrts_pkg::S_IDLE;
         end
      endcase
   end

   // At most one phase of an item is active in any cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.exec, cmd.rd_en, cmd.load}))
      else $error("controller issued overlapping commands");

endmodule

@@ src/rrts_datapath.sv @@
`timescale 1ns / 1ps

module rrts_datapath #(
   parameter int MAX_THREADS = rrts_pkg::MAX_THREADS_DEF,
   parameter int ID_BITS     = rrts_pkg::ID_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rrts_pkg::ctrl_cmd_type               cmd,
   output rrts_pkg::ctrl_status_type            status,
   input  logic [rrts_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 csr_wr_en,
   input  logic [rrts_pkg::SLICE_W-1:0]         csr_wr_data,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rrts_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int PTR_W = $clog2(MAX_THREADS);
   localparam int CNT_W = $clog2(MAX_THREADS + 1);
   localparam int EXT_W = (ID_BITS > rrts_pkg::TID_W) ? ID_BITS : rrts_pkg::TID_W;

   logic [rrts_pkg::OPCODE_W-1:0] opcode_ff;
   logic [ID_BITS-1:0]            id_ff;
   logic [EXT_W-1:0]              id_ext;
   logic [EXT_W-1:0]              head_ext;

   logic [PTR_W-1:0]            head_ff, head_in, head_next, tail;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [CNT_W-1:0]            blk_count_ff, blk_count_in;
   logic [CNT_W:0]              tail_sum, total;
   logic [MAX_THREADS-1:0]      blk_valid_ff, blk_valid_in;
   logic [ID_BITS-1:0]          blk_ids_ff [MAX_THREADS];
   logic [rrts_pkg::SLICE_W-1:0] slice_ticks_ff, slice_left_ff, slice_left_in, slice_dec;
   logic [rrts_pkg::ERR_W-1:0]  err_ff, err_in;
   logic [ID_BITS-1:0]          head_id_ff;
   logic                        rsp_valid_ff;
   logic [rrts_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic               ram_we;
   logic [ID_BITS-1:0] ram_wdata;
   logic [ID_BITS-1:0] ram_rdata;
   logic               blk_we;

   logic [PTR_W-1:0]   free_idx, match_idx;
   logic               free_found, match_found;

   rrts_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (MAX_THREADS)
   ) u_run_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   assign id_ext   = EXT_W'(req_tdata[rrts_pkg::OPCODE_W +: rrts_pkg::TID_W]);
   // The id read from the ring head, widened so that the result field can be cut from it.
   assign head_ext = EXT_W'(ram_rdata);

   assign head_next = (head_ff == PTR_W'(MAX_THREADS - 1)) ? '0 : head_ff + PTR_W'(1);
   assign tail_sum  = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
   always_comb begin
      if (tail_sum >= (CNT_W+1)'(MAX_THREADS)) begin
         tail = PTR_W'(tail_sum - (CNT_W+1)'(MAX_THREADS));
      end else begin
         tail = tail_sum[PTR_W-1:0];
      end
   end
   assign total     = (CNT_W+1)'(count_ff) + (CNT_W+1)'(blk_count_ff);
   assign slice_dec = slice_left_ff - rrts_pkg::SLICE_W'(1);

   // Lowest free blocked slot and lowest slot that holds the wake id.
   always_comb begin
      free_idx    = '0;
      free_found  = 1'b0;
      match_idx   = '0;
      match_found = 1'b0;
      for (int i = MAX_THREADS - 1; i >= 0; i--) begin
         if (!blk_valid_ff[i]) begin
            free_idx   = PTR_W'(i);
            free_found = 1'b1;
         end
         if (blk_valid_ff[i] && (blk_ids_ff[i] == id_ff)) begin
            match_idx   = PTR_W'(i);
            match_found = 1'b1;
         end
      end
   end

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      blk_count_in  = blk_count_ff;
      blk_valid_in  = blk_valid_ff;
      slice_left_in = slice_left_ff;
      err_in        = err_ff;
      ram_we        = 1'b0;
      ram_wdata     = id_ff;
      blk_we        = 1'b0;
      if (cmd.exec) begin
         err_in = rrts_pkg::ERR_OK;
         case (opcode_ff)
            rrts_pkg::OP_NEW: begin
               if (total >= (CNT_W+1)'(MAX_THREADS)) begin
                  err_in = rrts_pkg::ERR_NO_ROOM;
               end else begin
                  ram_we   = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  if (count_ff == '0) begin
                     slice_left_in = slice_ticks_ff;
                  end
               end
            end
            rrts_pkg::OP_EXIT: begin
               if (count_ff != '0) begin
                  head_in       = head_next;
                  count_in      = count_ff - CNT_W'(1);
                  slice_left_in = (count_ff > CNT_W'(1)) ? slice_ticks_ff : '0;
               end
            end
            rrts_pkg::OP_BLOCK: begin
               if ((count_ff != '0) && free_found) begin
                  blk_we                 = 1'b1;
                  blk_valid_in[free_idx] = 1'b1;
                  blk_count_in           = blk_count_ff + CNT_W'(1);
                  head_in                = head_next;
                  count_in               = count_ff - CNT_W'(1);
                  slice_left_in          = (count_ff > CNT_W'(1)) ? slice_ticks_ff : '0;
               end
            end
            rrts_pkg::OP_WAKE: begin
               if (match_found) begin
                  blk_valid_in[match_idx] = 1'b0;
                  blk_count_in            = blk_count_ff - CNT_W'(1);
                  if (count_ff < CNT_W'(MAX_THREADS)) begin
                     ram_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     if (count_ff == '0) begin
                        slice_left_in = slice_ticks_ff;
                     end
                  end
               end else begin
                  err_in = rrts_pkg::ERR_NOT_BLOCKED;
               end
            end
            rrts_pkg::OP_TICK: begin
               if (count_ff != '0) begin
                  if (slice_dec == '0) begin
                     // Slice used up: the head goes to the tail.
                     ram_we        = 1'b1;
                     ram_wdata     = head_id_ff;
                     head_in       = head_next;
                     slice_left_in = slice_ticks_ff;
                  end else begin
                     slice_left_in = slice_dec;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         count_ff       <= '0;
         blk_count_ff   <= '0;
         blk_valid_ff   <= '0;
         slice_left_ff  <= '0;
         slice_ticks_ff <= rrts_pkg::SLICE_RESET;
         err_ff         <= rrts_pkg::ERR_OK;
         rsp_valid_ff   <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         blk_count_ff  <= blk_count_in;
         blk_valid_ff  <= blk_valid_in;
         slice_left_ff <= slice_left_in;
         err_ff        <= err_in;
         if (csr_wr_en) begin
            slice_ticks_ff <= csr_wr_data;
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         opcode_ff <= req_tdata[rrts_pkg::OPCODE_W-1:0];
         id_ff     <= id_ext[ID_BITS-1:0];
      end
      if (blk_we) begin
         blk_ids_ff[free_idx] <= head_id_ff;
      end
      if (cmd.load) begin
         head_id_ff  <= ram_rdata;
         rsp_data_ff <= rrts_pkg::RSP_DATA_W'({err_ff,
            (count_ff != '0) ? head_ext[rrts_pkg::TID_W-1:0] : rrts_pkg::TID_W'(0),
            (count_ff != '0)});
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      total <= (CNT_W+1)'(MAX_THREADS))
      else $error("runnable plus blocked threads exceed capacity");

   assert property (@(posedge clock) disable iff (reset)
      $countones(blk_valid_ff) == int'(blk_count_ff))
      else $error("blocked count out of step with blocked slots");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (slice_left_ff == '0))
      else $error("slice counter running with an empty run queue");

endmodule

@@ sim/rrts_schedule_checker.sv @@
`timescale 1ns / 1ps

module rrts_schedule_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [rrts_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [rrts_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [rrts_pkg::SLICE_W-1:0]    csr_wr_data,
   output int                              fail_count,
   output int                              pending_count
);

   localparam int NT    = rrts_pkg::MAX_THREADS_DEF;
   localparam int PTR_W = $clog2(NT);
   localparam int CNT_W = PTR_W + 1;
   localparam int ID_W  = rrts_pkg::TID_W;
   localparam int SL_W  = rrts_pkg::SLICE_W;

   typedef struct packed {
      logic                       cur_valid;
      logic [ID_W-1:0]            cur_id;
      logic [rrts_pkg::ERR_W-1:0] err;
   } sched_result_type;

   // Shadow copy of the scheduler state.
   logic [ID_W-1:0]  ring_ids   [NT];
   logic [PTR_W-1:0] head_ptr;
   logic [CNT_W-1:0] run_cnt;
   logic [ID_W-1:0]  parked_ids [NT];
   logic [NT-1:0]    parked_valid;
   logic [SL_W-1:0]  ticks_left;
   logic [SL_W-1:0]  slice_len;

   sched_result_type sched_expected[$];
   int               errors = 0;

   task automatic enqueue_id(input logic [ID_W-1:0] id);
      if (run_cnt < NT) begin
         ring_ids[PTR_W'(head_ptr + run_cnt)] = id;
         run_cnt = run_cnt + 1'b1;
         if (run_cnt == 1) ticks_left = slice_len;
      end
   endtask

   task automatic dequeue_head(output logic [ID_W-1:0] id);
      id       = ring_ids[head_ptr];
      head_ptr = head_ptr + 1'b1;
      run_cnt  = run_cnt - 1'b1;
      ticks_left = (run_cnt != 0) ? slice_len : '0;
   endtask

   task automatic predict_schedule(input logic [rrts_pkg::OPCODE_W-1:0] op,
                                   input logic [ID_W-1:0] id,
                                   output sched_result_type res);
      int i;
      int slot;
      logic [ID_W-1:0] popped;
      res.err = rrts_pkg::ERR_OK;
      slot    = -1;
      case (op)
         rrts_pkg::OP_NEW: begin
            if (run_cnt + $countones(parked_valid) >= NT) res.err = rrts_pkg::ERR_NO_ROOM;
            else enqueue_id(id);
         end
         rrts_pkg::OP_EXIT: begin
            if (run_cnt != 0) dequeue_head(popped);
         end
         rrts_pkg::OP_BLOCK: begin
            if (run_cnt != 0) begin
               for (i = NT - 1; i >= 0; i--) if (!parked_valid[i]) slot = i;
               if (slot >= 0) begin
                  dequeue_head(popped);
                  parked_ids[slot]   = popped;
                  parked_valid[slot] = 1'b1;
               end
            end
         end
         rrts_pkg::OP_WAKE: begin
            // The lowest matching slot wins when an id is parked twice.
            for (i = NT - 1; i >= 0; i--)
               if (parked_valid[i] && parked_ids[i] == id) slot = i;
            if (slot >= 0) begin
               parked_valid[slot] = 1'b0;
               enqueue_id(parked_ids[slot]);
            end else begin
               res.err = rrts_pkg::ERR_NOT_BLOCKED;
            end
         end
         rrts_pkg::OP_TICK: begin
            if (run_cnt != 0) begin
               // A zero counter wraps to all ones and does not rotate.
               ticks_left = ticks_left - 1'b1;
               if (ticks_left == 0) begin
                  ring_ids[PTR_W'(head_ptr + run_cnt)] = ring_ids[head_ptr];
                  head_ptr   = head_ptr + 1'b1;
                  ticks_left = slice_len;
               end
            end
         end
         default: ;
      endcase
      res.cur_valid = (run_cnt != 0);
      res.cur_id    = (run_cnt != 0) ? ring_ids[head_ptr] : '0;
   endtask

   always @(posedge clock) begin : watch
      sched_result_type got;
      sched_result_type want;
      sched_result_type pred;
      int i;
      if (reset) begin
         for (i = 0; i < NT; i++) begin
            ring_ids[i]   = '0;
            parked_ids[i] = '0;
         end
         head_ptr     = '0;
         run_cnt      = '0;
         parked_valid = '0;
         ticks_left   = '0;
         slice_len    = rrts_pkg::SLICE_RESET;
         sched_expected.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.cur_valid = rsp_tdata[0];
            got.cur_id    = rsp_tdata[8:1];
            got.err       = rsp_tdata[10:9];
            if (sched_expected.size() == 0) begin
               $error("result item with no event pending, tdata %h", rsp_tdata);
               errors++;
            end else begin
               want = sched_expected.pop_front();
               if (got.cur_valid !== want.cur_valid) begin
                  $error("current_valid: expected %0d, actual %0d",
                         want.cur_valid, got.cur_valid);
                  errors++;
               end
               if (got.cur_id !== want.cur_id) begin
                  $error("current_id: expected %0d, actual %0d", want.cur_id, got.cur_id);
                  errors++;
               end
               if (got.err !== want.err) begin
                  $error("error_code: expected %0d, actual %0d", want.err, got.err);
                  errors++;
               end
               if (rsp_tdata[rrts_pkg::RSP_DATA_W-1:11] !== '0) begin
                  $error("zero_fill: expected 0, actual %0d",
                         rsp_tdata[rrts_pkg::RSP_DATA_W-1:11]);
                  errors++;
               end
            end
         end
         if (csr_wr_en) slice_len = csr_wr_data;
         if (req_tvalid && req_tready) begin
            predict_schedule(req_tdata[2:0], req_tdata[10:3], pred);
            sched_expected.push_back(pred);
         end
      end
      fail_count    <= errors;
      pending_count <= sched_expected.size();
   end

endmodule

@@ sim/tb_round_robin_thread_scheduler_top.sv @@
`timescale 1ns / 1ps

module tb_round_robin_thread_scheduler_top;

   localparam int OP_W  = rrts_pkg::OPCODE_W;
   localparam int ID_W  = rrts_pkg::TID_W;
   localparam int SL_W  = rrts_pkg::SLICE_W;
   localparam int REQ_W = rrts_pkg::REQ_DATA_W;
   localparam int RSP_W = rrts_pkg::RSP_DATA_W;

   // Number of random events per configuration phase and number of phases.
   localparam int PHASE_ITEMS = 150;
   localparam int PHASES      = 8;
   // Margin allowed after the last result is taken, before a register write
   // or the verdict.
   localparam int DRAIN_CYCLES = 8;
   // Length of the one long result-side hold-off that fills the block up.
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int POOL_SIZE = 12;

   // Every input of the block has a known value from time zero.
   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic [REQ_W-1:0] req_tdata   = '0;
   logic             rsp_tready  = 1'b0;
   logic             csr_wr_en   = 1'b0;
   logic [SL_W-1:0]  csr_wr_data = '0;
   wire              req_tready;
   wire              rsp_tvalid;
   wire [RSP_W-1:0]  rsp_tdata;

   int fail_count;
   int pending_count;

   // Knobs that the stimulus process sets for the sender task and the result sink.
   logic quiet         = 1'b0;
   logic hold_request  = 1'b0;
   int   sink_idle_pct = 0;
   int   src_idle_pct  = 0;

   round_robin_thread_scheduler_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // The checker watches both channels and the register port, predicts each
   // result and reports how many mismatches it saw and how many results
   // it still waits for.
   rrts_schedule_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A hung handshake ends the run here. The bound is many times the slowest
   // legal run, in which every event waits out the longest gaps on both sides.
   initial begin
      #5_000_000;
      $display("tb_round_robin_thread_scheduler_top failed");
      $finish;
   end

   // Offers one event item and returns at the edge that accepts it. Valid is
   // lowered only for an idle burst, so back-to-back items keep it high.
   task automatic send_event(input logic [OP_W-1:0] op,
                             input logic [ID_W-1:0] id);
      if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - OP_W - ID_W){1'b0}}, id, op};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering and waits until every predicted result has been taken,
   // then lets the block settle. The first edge lets the checker count the
   // item accepted at the current edge.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_slice(input logic [SL_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // Result sink. It stalls in random bursts, holds off once for a long
   // stretch so that the block backs up into its input, and never stalls in
   // the last phase.
   initial begin : rsp_sink
      logic hold_served;
      hold_served = 1'b0;
      forever begin
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 99) < sink_idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [SL_W-1:0] slice_plan [PHASES];
      int              src_plan   [PHASES];
      int              sink_plan  [PHASES];
      int              new_plan   [PHASES];
      logic [ID_W-1:0] id_pool    [POOL_SIZE];
      logic [OP_W-1:0] op;
      logic [ID_W-1:0] id;
      int              ph;
      int              n;
      int              k;
      int              r;

      // Slice lengths per phase: zero first, so the counter wrap is reached,
      // then the largest value, the shortest legal slices and random ones.
      slice_plan = '{16'd0, 16'hFFFF, 16'd1, 16'd2, 16'd3,
                     SL_W'($urandom_range(1, 8)), SL_W'($urandom_range(0, 65535)),
                     16'd1};
      // Sender and sink idling per phase; some phases have none at all.
      src_plan  = '{30, 0, 10, 20, 40, 0, 30, 0};
      sink_plan = '{30, 20, 0, 50, 10, 0, 40, 0};
      // Share of new-thread events; a low share lets the queue drain to empty.
      new_plan  = '{28, 28, 30, 12, 28, 20, 35, 25};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset slice length of one tick.
      // Exit, block and tick on an empty queue do nothing.
      send_event(rrts_pkg::OP_TICK,  ID_W'($urandom));
      send_event(rrts_pkg::OP_EXIT,  ID_W'($urandom));
      send_event(rrts_pkg::OP_BLOCK, ID_W'($urandom));
      // Waking an id that is not blocked reports an error.
      send_event(rrts_pkg::OP_WAKE,  8'hFF);
      // Extreme ids, then a tick that rotates the head at once.
      send_event(rrts_pkg::OP_NEW,   8'h00);
      send_event(rrts_pkg::OP_NEW,   8'hFF);
      send_event(rrts_pkg::OP_TICK,  ID_W'($urandom));
      send_event(rrts_pkg::OP_BLOCK, ID_W'($urandom));
      send_event(rrts_pkg::OP_WAKE,  8'hFF);
      // The same id twice, both blocked, so wake has to pick a slot.
      send_event(rrts_pkg::OP_NEW,   8'h5A);
      send_event(rrts_pkg::OP_NEW,   8'h5A);
      repeat (4) send_event(rrts_pkg::OP_BLOCK, ID_W'($urandom));
      send_event(rrts_pkg::OP_TICK,  ID_W'($urandom));
      send_event(rrts_pkg::OP_WAKE,  8'h5A);
      send_event(rrts_pkg::OP_WAKE,  8'h5A);
      send_event(rrts_pkg::OP_WAKE,  8'h5A);
      send_event(rrts_pkg::OP_WAKE,  8'h00);
      // Undefined opcodes leave everything as it is.
      send_event(3'd5,               ID_W'($urandom));
      send_event(3'd6,               ID_W'($urandom));
      send_event(3'd7,               ID_W'($urandom));
      send_event(rrts_pkg::OP_EXIT,  ID_W'($urandom));
      send_event(rrts_pkg::OP_EXIT,  ID_W'($urandom));
      send_event(rrts_pkg::OP_EXIT,  ID_W'($urandom));

      // Random part. Each phase first drains the block, which is also the
      // pause in which the sender waits for every result, then sets a new
      // slice length. Ids come mostly from a small pool, so that wakes find
      // blocked threads, duplicates occur and the scheduler fills up.
      for (ph = 0; ph < PHASES; ph++) begin
         wait_idle();
         write_slice(slice_plan[ph]);
         for (k = 0; k < POOL_SIZE; k++) id_pool[k] = ID_W'($urandom_range(0, 255));
         src_idle_pct   = src_plan[ph];
         sink_idle_pct <= sink_plan[ph];
         if (ph == 2) hold_request <= 1'b1;
         if (ph == PHASES - 1) quiet <= 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < new_plan[ph])            op = rrts_pkg::OP_NEW;
            else if (r < new_plan[ph] + 10)  op = rrts_pkg::OP_EXIT;
            else if (r < new_plan[ph] + 30)  op = rrts_pkg::OP_BLOCK;
            else if (r < new_plan[ph] + 50)  op = rrts_pkg::OP_WAKE;
            else if (r < 95)                 op = rrts_pkg::OP_TICK;
            else                             op = OP_W'($urandom_range(5, 7));
            if ($urandom_range(0, 99) < 85) id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            else id = ID_W'($urandom_range(0, 255));
            send_event(op, id);
         end
      end

      wait_idle();
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_round_robin_thread_scheduler_top passed");
      end else begin
         $display("tb_round_robin_thread_scheduler_top failed");
      end
      $finish;
   end

endmodule
